// ===== src/get3x3_pkg.sv =====
package get3x3_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = 16;
	localparam int PIX_W       = 8;
	localparam int THR_W       = 11;
	localparam int WID_W       = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 2;

	// gradient arithmetic: sums reach +/-1020, squares stay below 2^20
	localparam int SUM_W = 10;
	localparam int GRAD_W = 11;
	localparam int SQ_W  = 20;
	localparam int MAG_W = 21;
	localparam int LIM_W = 23;

	localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
	localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

	localparam logic [THR_W-1:0] THR_RESET    = 11'd80;
	localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd480;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OPERATOR_MODE,
		CFG_EDGE_THRESHOLD,
		CFG_IMAGE_WIDTH,
		CFG_IMAGE_HEIGHT
	} cfg_reg_t;

	typedef struct packed {
		logic             restart;
		logic [WID_W-1:0] image_width;
		logic [ROW_W-1:0] image_height;
	} geom_cfg_t;

	typedef struct packed {
		logic             operator_mode;
		logic [THR_W-1:0] edge_threshold;
	} kern_cfg_t;

	// window without its centre, p<row><col>, col 0 oldest
	typedef struct packed {
		pix_t p00;
		pix_t p10;
		pix_t p20;
		pix_t p01;
		pix_t p21;
		pix_t p02;
		pix_t p12;
		pix_t p22;
		logic last;
	} win_item_t;

endpackage

// ===== src/get3x3_front.sv =====
module get3x3_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  get3x3_pkg::geom_cfg_t  geom,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  get3x3_pkg::pix_t       pixel_in,
	input  logic                   q_ready,
	output logic                   q_push,
	output get3x3_pkg::win_item_t  q_item
);

	localparam int COL_W = get3x3_pkg::COL_W;
	localparam int ROW_W = get3x3_pkg::ROW_W;

	get3x3_pkg::pix_t lo_mem [get3x3_pkg::MAX_WIDTH];
	get3x3_pkg::pix_t hi_mem [get3x3_pkg::MAX_WIDTH];

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic             s1_valid_q;
	get3x3_pkg::pix_t pix_s1;
	get3x3_pkg::pix_t rd_mid_s1;
	get3x3_pkg::pix_t rd_top_s1;
	logic [COL_W-1:0] idx_s1;
	logic             int_s1;
	logic             last_s1;

	get3x3_pkg::pix_t wc_q [6];

	logic [15:0]      w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [COL_W-1:0] col_last;
	logic [ROW_W-1:0] row_last;
	logic             col_end;
	logic             row_end;
	logic             accept;
	logic             s1_adv;

	always_comb begin
		w_eff = {5'd0, geom.image_width};
		if (w_eff < 16'd3) begin
			w_eff = 16'd3;
		end else if (w_eff > 16'(get3x3_pkg::MAX_WIDTH)) begin
			w_eff = 16'(get3x3_pkg::MAX_WIDTH);
		end
		h_eff = (geom.image_height < 16'd3) ? 16'd3 : geom.image_height;
	end

	assign col_last = COL_W'(w_eff - 16'd1);
	assign row_last = h_eff - 16'd1;
	assign col_end  = (col_q == col_last);
	assign row_end  = (row_q == row_last);

	assign s1_adv   = s1_valid_q && (!int_s1 || q_ready);
	assign in_stall = s1_valid_q && !s1_adv;
	assign accept   = in_valid && !in_stall;
	assign q_push   = s1_valid_q && int_s1 && q_ready;

	assign q_item = '{
		p00:  wc_q[0],
		p10:  wc_q[1],
		p20:  wc_q[2],
		p01:  wc_q[3],
		p21:  wc_q[5],
		p02:  rd_top_s1,
		p12:  rd_mid_s1,
		p22:  pix_s1,
		last: last_s1
	};

	// raster position of the next request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (geom.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel_in;
			idx_s1  <= col_q;
			int_s1  <= (row_q >= 16'd2) && (col_q >= COL_W'(2));
			last_s1 <= row_end && col_end;
		end
	end

	// line stores: read on acceptance, write back when the request leaves
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_mid_s1 <= lo_mem[col_q];
			rd_top_s1 <= hi_mem[col_q];
		end
		if (s1_adv) begin
			lo_mem[idx_s1] <= pix_s1;
			hi_mem[idx_s1] <= rd_mid_s1;
		end
	end

	// advance the window by one column
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			wc_q[0] <= wc_q[3];
			wc_q[1] <= wc_q[4];
			wc_q[2] <= wc_q[5];
			wc_q[3] <= rd_top_s1;
			wc_q[4] <= rd_mid_s1;
			wc_q[5] <= pix_s1;
		end
	end

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(pix_s1) && $stable(idx_s1))
		else $error("front stage lost a blocked request");

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !geom.restart && col_end |=> col_q == '0)
		else $error("column counter did not wrap at line end");

endmodule

// ===== src/get3x3_queue.sv =====
module get3x3_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  get3x3_pkg::win_item_t push_item,
	output logic                  push_ready,
	input  logic                  pop,
	output logic                  pop_valid,
	output get3x3_pkg::win_item_t pop_item
);

	localparam int DEPTH = get3x3_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	get3x3_pkg::win_item_t mem_q [DEPTH];

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && cnt_q == CNT_W'(DEPTH)))
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && cnt_q == '0))
		else $error("pop from an empty queue");

endmodule

// ===== src/get3x3_back.sv =====
module get3x3_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  get3x3_pkg::kern_cfg_t kcfg,
	input  logic                  q_valid,
	input  get3x3_pkg::win_item_t q_item,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output get3x3_pkg::pix_t      edge_value,
	output logic                  frame_last
);

	localparam int SUM_W  = get3x3_pkg::SUM_W;
	localparam int GRAD_W = get3x3_pkg::GRAD_W;
	localparam int SQ_W   = get3x3_pkg::SQ_W;
	localparam int MAG_W  = get3x3_pkg::MAG_W;
	localparam int LIM_W  = get3x3_pkg::LIM_W;
	localparam int THR_W  = get3x3_pkg::THR_W;

	logic                     b1_valid_q;
	logic signed [GRAD_W-1:0] sx_s1;
	logic signed [GRAD_W-1:0] sy_s1;
	logic                     last_s1;

	logic                     b2_valid_q;
	logic [SQ_W-1:0]          sqx_s2;
	logic [SQ_W-1:0]          sqy_s2;
	logic                     last_s2;

	logic                     out_valid_q;
	get3x3_pkg::pix_t         edge_q;
	logic                     last_q;

	logic [LIM_W-1:0]         lim_q;

	logic                     out_ready;
	logic                     b2_ready;
	logic                     b1_ready;

	logic [SUM_W-1:0]         sx_pos;
	logic [SUM_W-1:0]         sx_neg;
	logic [SUM_W-1:0]         sy_pos;
	logic [SUM_W-1:0]         sy_neg;
	logic [SUM_W-1:0]         k_p12;
	logic [SUM_W-1:0]         k_p10;
	logic [SUM_W-1:0]         k_p21;
	logic [SUM_W-1:0]         k_p01;
	logic signed [2*GRAD_W-1:0] sqx_full;
	logic signed [2*GRAD_W-1:0] sqy_full;
	logic [MAG_W-1:0]         mag2;
	logic [THR_W:0]           thr_p1;
	logic [2*THR_W+1:0]       lim_full;

	assign out_ready = !out_valid_q || !out_stall;
	assign b2_ready  = !b2_valid_q || out_ready;
	assign b1_ready  = !b1_valid_q || b2_ready;
	assign q_pop     = q_valid && b1_ready;

	// centre weight 1 for Prewitt, 2 for Sobel
	function automatic logic [SUM_W-1:0] weigh(input logic prewitt, input get3x3_pkg::pix_t p);
		weigh = prewitt ? {2'b00, p} : {1'b0, p, 1'b0};
	endfunction

	assign k_p12 = weigh(kcfg.operator_mode, q_item.p12);
	assign k_p10 = weigh(kcfg.operator_mode, q_item.p10);
	assign k_p21 = weigh(kcfg.operator_mode, q_item.p21);
	assign k_p01 = weigh(kcfg.operator_mode, q_item.p01);

	assign sx_pos = {2'b00, q_item.p02} + k_p12 + {2'b00, q_item.p22};
	assign sx_neg = {2'b00, q_item.p00} + k_p10 + {2'b00, q_item.p20};
	assign sy_pos = {2'b00, q_item.p20} + k_p21 + {2'b00, q_item.p22};
	assign sy_neg = {2'b00, q_item.p00} + k_p01 + {2'b00, q_item.p02};

	assign sqx_full = sx_s1 * sx_s1;
	assign sqy_full = sy_s1 * sy_s1;
	assign mag2     = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	assign thr_p1   = {1'b0, kcfg.edge_threshold} + 1'b1;
	assign lim_full = thr_p1 * thr_p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_q  <= 1'b0;
			b2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (b1_ready) begin
				b1_valid_q <= q_valid;
			end
			if (b2_ready) begin
				b2_valid_q <= b1_valid_q;
			end
			if (out_ready) begin
				out_valid_q <= b2_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		// squared threshold is registered from the threshold config register, so it settles after a write
		lim_q <= lim_full[LIM_W-1:0];
		if (b1_ready && q_valid) begin
			sx_s1   <= $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
			sy_s1   <= $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
			last_s1 <= q_item.last;
		end
		if (b2_ready && b1_valid_q) begin
			sqx_s2  <= sqx_full[SQ_W-1:0];
			sqy_s2  <= sqy_full[SQ_W-1:0];
			last_s2 <= last_s1;
		end
		if (out_ready && b2_valid_q) begin
			edge_q <= ({{(LIM_W-MAG_W){1'b0}}, mag2} >= lim_q) ?
				get3x3_pkg::EDGE_ON : get3x3_pkg::EDGE_OFF;
			last_q <= last_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign edge_value = edge_q;
	assign frame_last = last_q;

	a_b2_drain: assert property (@(posedge clk) disable iff (!arst_n)
		b2_valid_q && out_ready |=> out_valid_q)
		else $error("result lost between square stage and output register");

	a_b1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		b1_valid_q && !b2_ready |=> b1_valid_q && $stable(sx_s1) && $stable(sy_s1))
		else $error("gradient stage overwritten while blocked");

endmodule

// ===== src/gradient_edge_threshold_3x3_unit.sv =====
// channel   direction  handshake              payload
// pixel     in         in_valid / in_stall    pixel_in[7:0]
// result    out        out_valid / out_stall  edge_value[7:0], frame_last
// config    in         cfg_wr_en              cfg_index[1:0], cfg_data[15:0]
//
// One pixel per clock sustained while in_stall stays low; each pixel does one read and one write in each line store.
// A result passes the front stage, the queue, then the gradient, square and output registers before it is offered.
// Reset clears counters, pipeline valids and config registers to defaults; line stores are not cleared.
// out_stall backs up the gradient stages, then a two-entry queue, then in_stall.
module gradient_edge_threshold_3x3_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [get3x3_pkg::PIX_W-1:0]        pixel_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [get3x3_pkg::PIX_W-1:0]        edge_value,
	output logic                                frame_last,
	input  logic                                cfg_wr_en,
	input  logic [get3x3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [get3x3_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                                  mode_q;
	logic [get3x3_pkg::THR_W-1:0]          thr_q;
	logic [get3x3_pkg::WID_W-1:0]          width_q;
	logic [get3x3_pkg::ROW_W-1:0]          height_q;

	get3x3_pkg::geom_cfg_t  geom;
	get3x3_pkg::kern_cfg_t  kcfg;
	get3x3_pkg::win_item_t  push_item;
	get3x3_pkg::win_item_t  pop_item;
	logic                   push;
	logic                   push_ready;
	logic                   pop;
	logic                   pop_valid;
	logic                   restart;

	get3x3_pkg::cfg_reg_t   cfg_sel;

	assign cfg_sel = get3x3_pkg::cfg_reg_t'(cfg_index);
	assign restart = cfg_wr_en &&
		(cfg_sel == get3x3_pkg::CFG_IMAGE_WIDTH || cfg_sel == get3x3_pkg::CFG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			thr_q    <= get3x3_pkg::THR_RESET;
			width_q  <= get3x3_pkg::WIDTH_RESET;
			height_q <= get3x3_pkg::HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_sel)
				get3x3_pkg::CFG_OPERATOR_MODE: begin
					mode_q <= cfg_data[0];
				end
				get3x3_pkg::CFG_EDGE_THRESHOLD: begin
					thr_q <= cfg_data[get3x3_pkg::THR_W-1:0];
				end
				get3x3_pkg::CFG_IMAGE_WIDTH: begin
					width_q <= cfg_data[get3x3_pkg::WID_W-1:0];
				end
				get3x3_pkg::CFG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[get3x3_pkg::ROW_W-1:0];
				end
				default: begin
					mode_q <= mode_q;
				end
			endcase
		end
	end

	assign geom = '{restart: restart, image_width: width_q, image_height: height_q};
	assign kcfg = '{operator_mode: mode_q, edge_threshold: thr_q};

	get3x3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.pixel_in (pixel_in),
		.q_ready  (push_ready),
		.q_push   (push),
		.q_item   (push_item)
	);

	get3x3_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item)
	);

	get3x3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.kcfg       (kcfg),
		.q_valid    (pop_valid),
		.q_item     (pop_item),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.edge_value (edge_value),
		.frame_last (frame_last)
	);

endmodule
